// ===== src/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg: shared types and constants for the bounce scanner
// Phase codes, register indexes and fixed widths used by all modules.
// ----------------------------------------------------------------------------
package lbs_pkg;

  // fixed field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ColorW = 8;
  localparam int unsigned EyeW   = 5;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned CfgIdxW = 3;
  // arithmetic width for position math, covers strips up to 64 pixels
  localparam int unsigned CalcW  = 7;

  // scanner phase
  typedef enum logic [1:0] {
    PH_FWD       = 2'd0,
    PH_HOLD_FAR  = 2'd1,
    PH_BACK      = 2'd2,
    PH_HOLD_NEAR = 2'd3
  } phase_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_EYE_RED     = 3'd0,
    REG_EYE_GREEN   = 3'd1,
    REG_EYE_BLUE    = 3'd2,
    REG_EYE_WIDTH   = 3'd3,
    REG_STEP_DELAY  = 3'd4,
    REG_PAUSE_DELAY = 3'd5
  } reg_idx_e;

  // eye color as one group
  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } color_t;

endpackage

// ===== src/lbs_front.sv =====
// ----------------------------------------------------------------------------
// lbs_front: time-tick front end
// Runs the four-phase eye motion and issues one draw command per drawn frame.
// ----------------------------------------------------------------------------
module lbs_front #(
  parameter int unsigned PIXELS = 24,
  parameter int unsigned PosW   = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [lbs_pkg::TimeW-1:0]   now_i,
  input  logic [lbs_pkg::EyeW-1:0]    eye_width_i,
  input  logic [lbs_pkg::ColorW-1:0]  step_delay_i,
  input  logic [lbs_pkg::ColorW-1:0]  pause_delay_i,
  output logic                        cmd_push_o,
  output logic [PosW-1:0]             cmd_left_o,
  output logic [lbs_pkg::EyeW-1:0]    cmd_eye_o
);
  import lbs_pkg::*;

  localparam logic [CalcW-1:0] Cap     = CalcW'(PIXELS - 3);
  localparam logic [CalcW-1:0] EndBase = CalcW'(PIXELS - 2);

  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [TimeW-1:0]  last_q, last_d;

  logic [TimeW-1:0]  elapsed;
  logic              step_hit, pause_hit;
  logic [EyeW-1:0]   eff;
  logic [CalcW-1:0]  limit;
  logic [CalcW-1:0]  pos_ext;
  logic              draw;

  // elapsed time, wrapping, strictly greater than the delay
  assign elapsed   = now_i - last_q;
  assign step_hit  = elapsed > TimeW'(step_delay_i);
  assign pause_hit = elapsed > TimeW'(pause_delay_i);

  // saturated eye width and far-end position
  assign eff     = (CalcW'(eye_width_i) > Cap) ? EyeW'(Cap) : eye_width_i;
  assign limit   = EndBase - CalcW'(eff);
  assign pos_ext = CalcW'(pos_q);

  // phase, position and last-time registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FWD;
      pos_q   <= '0;
      last_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      last_q  <= last_d;
    end
  end

  // next phase and draw decision
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    last_d  = last_q;
    draw    = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        PH_FWD: begin
          if (step_hit) begin
            last_d = now_i;
            if (pos_ext < limit) begin
              draw  = 1'b1;
              pos_d = pos_q + 1'b1;
            end else begin
              phase_d = PH_HOLD_FAR;
            end
          end
        end
        PH_HOLD_FAR: begin
          if (pause_hit) begin
            last_d  = now_i;
            pos_d   = limit[PosW-1:0];
            phase_d = PH_BACK;
          end
        end
        PH_BACK: begin
          if (step_hit) begin
            last_d = now_i;
            if (pos_q != '0) begin
              draw  = 1'b1;
              pos_d = pos_q - 1'b1;
            end else begin
              phase_d = PH_HOLD_NEAR;
            end
          end
        end
        PH_HOLD_NEAR: begin
          if (pause_hit) begin
            last_d  = now_i;
            pos_d   = '0;
            phase_d = PH_FWD;
          end
        end
        default: begin
          phase_d = PH_FWD;
        end
      endcase
    end
  end

  assign cmd_push_o = draw;
  assign cmd_left_o = pos_q;
  assign cmd_eye_o  = eff;

`ifndef NO_ASSERTIONS
  // frames are drawn only while moving
  a_draw_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push_o |-> (phase_q == PH_FWD || phase_q == PH_BACK))
    else $error("draw command issued in a pause phase");
`endif

endmodule

// ===== src/lbs_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// lbs_cmd_fifo: two-entry draw command queue
// Decouples the tick front end from the pixel generator.
// ----------------------------------------------------------------------------
module lbs_cmd_fifo #(
  parameter int unsigned DataW = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o,
  output logic             empty_o
);
  import lbs_pkg::*;

  logic [DataW-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("command queue underflow");
`endif

endmodule

// ===== src/lbs_back.sv =====
// ----------------------------------------------------------------------------
// lbs_back: pixel generator
// Expands a draw command into a frame, one pixel beat per unstalled cycle.
// ----------------------------------------------------------------------------
module lbs_back #(
  parameter int unsigned PIXELS = 24,
  parameter int unsigned PosW   = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  logic [PosW-1:0]             cmd_left_i,
  input  logic [lbs_pkg::EyeW-1:0]    cmd_eye_i,
  output logic                        cmd_pop_o,
  input  lbs_pkg::color_t             color_i,
  output logic                        out_valid_o,
  input  logic                        out_pop_i,
  output logic [lbs_pkg::IdxW-1:0]    pixel_index_o,
  output lbs_pkg::color_t             pixel_o,
  output logic                        frame_end_o
);
  import lbs_pkg::*;

  localparam logic [PosW-1:0] LastPix = PosW'(PIXELS - 1);

  logic [PosW-1:0]  k_q;
  logic             vld_q;
  logic [IdxW-1:0]  idx_q;
  color_t           pix_q;
  logic             end_q;

  logic             emit, last;
  logic [CalcW-1:0] kk, lft, rgt;
  logic             quarter, full;
  color_t           pix_d;

  assign emit = cmd_valid_i && (!vld_q || out_pop_i);
  assign last = (k_q == LastPix);
  assign cmd_pop_o = emit && last;

  // pixel classification against the eye span
  assign kk  = CalcW'(k_q);
  assign lft = CalcW'(cmd_left_i);
  assign rgt = lft + CalcW'(cmd_eye_i);
  assign quarter = (kk == lft) || (kk == rgt + 1'b1);
  assign full    = (kk > lft) && (kk <= rgt);

  always_comb begin
    pix_d = '0;
    if (quarter) begin
      pix_d.red   = color_i.red   >> 2;
      pix_d.green = color_i.green >> 2;
      pix_d.blue  = color_i.blue  >> 2;
    end else if (full) begin
      pix_d = color_i;
    end
  end

  // pixel counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (emit) begin
        k_q   <= last ? '0 : k_q + 1'b1;
        vld_q <= 1'b1;
      end else if (out_pop_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      idx_q <= IdxW'(k_q);
      pix_q <= pix_d;
      end_q <= last;
    end
  end

  assign out_valid_o   = vld_q;
  assign pixel_index_o = idx_q;
  assign pixel_o       = pix_q;
  assign frame_end_o   = end_q;

`ifndef NO_ASSERTIONS
  a_ctr_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (k_q == '0))
    else $error("pixel counter did not wrap after frame");
  a_ctr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= LastPix)
    else $error("pixel counter out of range");
`endif

endmodule

// ===== src/led_bounce_scanner_core.sv =====
// ----------------------------------------------------------------------------
// led_bounce_scanner_core: bouncing-eye strip scanner
// Config registers, tick front end, command queue and pixel generator.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive now_i with the time count and raise push; a beat is
//   taken when push is high and full is low. A tick that draws nothing is
//   absorbed as it is taken. A tick that draws queues one command and yields
//   PIXELS result beats.
//   Result queue: while empty is low the oldest pixel is on the pixel ports;
//   pop takes it. Pixels come in ascending index order, frame_end marks the
//   last one of a frame.
//   Path: a drawing tick's command is written into the command queue, and
//   its pixels are then registered in the output register by the generator.
//   Throughput: one pixel per cycle while the output is popped, set by the
//   pixel generator; the two-entry command queue lets the next ticks be
//   taken while a frame streams out.
//   Stall: a pop held low freezes the output register and the generator;
//   once the command queue holds two frames, full rises.
//   Reset: phase forward, position 0, last time 0, registers to defaults.
//   Config: write cfg_we_i / cfg_idx_i / cfg_data_i only when idle.
// ----------------------------------------------------------------------------
module led_bounce_scanner_core #(
  parameter int unsigned PIXELS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lbs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lbs_pkg::ColorW-1:0]    cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [lbs_pkg::TimeW-1:0]     now_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [lbs_pkg::IdxW-1:0]      pixel_index_o,
  output logic [lbs_pkg::ColorW-1:0]    pixel_red_o,
  output logic [lbs_pkg::ColorW-1:0]    pixel_green_o,
  output logic [lbs_pkg::ColorW-1:0]    pixel_blue_o,
  output logic                          frame_end_o
);
  import lbs_pkg::*;

  localparam int unsigned PosW = $clog2(PIXELS);
  localparam int unsigned CmdW = PosW + EyeW;

  color_t            color_q;
  logic [EyeW-1:0]   eye_width_q;
  logic [ColorW-1:0] step_q, pause_q;

  logic              accept;
  logic              cmd_push, cmd_pop, cmd_empty;
  logic [PosW-1:0]   cmd_left;
  logic [EyeW-1:0]   cmd_eye;
  logic [CmdW-1:0]   fifo_out;
  logic              out_valid;
  color_t            pix;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q.red   <= 8'd255;
      color_q.green <= 8'd0;
      color_q.blue  <= 8'd0;
      eye_width_q   <= 5'd3;
      step_q        <= 8'd10;
      pause_q       <= 8'd50;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EYE_RED:     color_q.red   <= cfg_data_i;
        REG_EYE_GREEN:   color_q.green <= cfg_data_i;
        REG_EYE_BLUE:    color_q.blue  <= cfg_data_i;
        REG_EYE_WIDTH:   eye_width_q   <= cfg_data_i[EyeW-1:0];
        REG_STEP_DELAY:  step_q        <= cfg_data_i;
        REG_PAUSE_DELAY: pause_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  lbs_front #(
    .PIXELS (PIXELS),
    .PosW   (PosW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .now_i         (now_i),
    .eye_width_i   (eye_width_q),
    .step_delay_i  (step_q),
    .pause_delay_i (pause_q),
    .cmd_push_o    (cmd_push),
    .cmd_left_o    (cmd_left),
    .cmd_eye_o     (cmd_eye)
  );

  lbs_cmd_fifo #(
    .DataW (CmdW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  ({cmd_left, cmd_eye}),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (fifo_out),
    .empty_o (cmd_empty)
  );

  lbs_back #(
    .PIXELS (PIXELS),
    .PosW   (PosW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!cmd_empty),
    .cmd_left_i    (fifo_out[CmdW-1:EyeW]),
    .cmd_eye_i     (fifo_out[EyeW-1:0]),
    .cmd_pop_o     (cmd_pop),
    .color_i       (color_q),
    .out_valid_o   (out_valid),
    .out_pop_i     (pop),
    .pixel_index_o (pixel_index_o),
    .pixel_o       (pix),
    .frame_end_o   (frame_end_o)
  );

  assign empty         = !out_valid;
  assign pixel_red_o   = pix.red;
  assign pixel_green_o = pix.green;
  assign pixel_blue_o  = pix.blue;

endmodule
